/* hw/rtl/upd_pkg.sv */
// Shared constants, types and character helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // Most results that one request can cause.
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  // Entries in the queue between classifier and serialiser; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Held characters: none, a '%', or a '%' and one hex digit.
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  // All the results caused by one request, oldest in slot zero.
  typedef struct packed {
    logic [CNT_W-1:0]                  cnt;
    logic [MAX_RESULTS-1:0][7:0]       bytes;
    logic                              str_end;
  } upd_entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_LA) && (c <= CHAR_LF)) ||
           ((c >= CHAR_UA) && (c <= CHAR_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= CHAR_0) && (c <= CHAR_9)) begin
      v = c - CHAR_0;
    end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
      v = c - CHAR_LA + 8'd10;
    end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
      v = c - CHAR_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

/* hw/rtl/upd_ifs.sv */
// Valid/ready channel interfaces for the decoder's input and result streams.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;
  modport source (output valid, out_byte, run_last, string_end, input ready);
  modport sink   (input valid, out_byte, run_last, string_end, output ready);
endinterface

/* hw/rtl/url_percent_decoder_top.sv */
// Top level of the URL percent decoder: classifier, queue and serialiser.
//
//  Channel | Direction | Payload                          | Handshake
//  in_ch   | sink      | in_byte[7:0], in_last            | valid/ready
//  out_ch  | source    | out_byte[7:0], run_last, string_end | valid/ready
//
// One request is classified in the cycle it is accepted; the serialiser then
// emits one decoded byte per cycle while the output is not stalled, so a
// request yields as many bytes as the results it causes, at most three. A
// request that only holds characters emits nothing. Results pass through the
// queue and then the output register. Reset is synchronous and active low;
// it clears the held state, the queue and the output valid flag. Input ready
// falls only when the two-entry queue is full, which happens when
// multi-result requests or output stalls outpace the serialiser.
module url_percent_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  upd_entry_t q_wdata;
  upd_entry_t q_rdata;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  upd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  upd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* hw/rtl/upd_front.sv */
// Classifier: accepts encoded characters and turns each into a bundle of results.
module upd_front (
  input  logic                clk,
  input  logic                rst_n,
  upd_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output upd_pkg::upd_entry_t q_wdata
);
  import upd_pkg::*;

  logic [1:0] held_r, held_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic       accept;

  logic [CNT_W-1:0]            n;
  logic [MAX_RESULTS-1:0][7:0] slot;
  logic                        take_plain;
  logic                        b_hex;
  logic [7:0]                  b;
  logic [7:0]                  plain_byte;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign b_hex       = is_hex(b);
  assign plain_byte  = (b == CHAR_PLUS) ? CHAR_SPACE : b;

  always_comb begin
    n          = '0;
    slot       = '0;
    take_plain = 1'b0;
    held_nxt   = held_r;
    digit_nxt  = digit_r;

    unique case (held_r)
      HELD_NONE: begin
        take_plain = 1'b1;
      end
      HELD_PCT: begin
        if (b_hex) begin
          held_nxt  = HELD_DIGIT;
          digit_nxt = b;
        end else begin
          held_nxt   = HELD_NONE;
          slot[n]    = CHAR_PCT;
          n          = n + 1'b1;
          take_plain = 1'b1;
        end
      end
      default: begin
        // A held count of three cannot arise; it behaves like two.
        held_nxt  = HELD_NONE;
        digit_nxt = 8'd0;
        if (b_hex && is_hex(digit_r)) begin
          slot[n] = {hex_val(digit_r), hex_val(b)};
          n       = n + 1'b1;
        end else begin
          slot[n]    = CHAR_PCT;
          n          = n + 1'b1;
          slot[n]    = digit_r;
          n          = n + 1'b1;
          take_plain = 1'b1;
        end
      end
    endcase

    if (take_plain) begin
      if (b == CHAR_PCT) begin
        held_nxt = HELD_PCT;
      end else if (n < CNT_W'(MAX_RESULTS)) begin
        slot[n] = plain_byte;
        n       = n + 1'b1;
      end
    end

    // At string end whatever is still held goes out literally.
    if (in_ch.in_last) begin
      if ((held_nxt != HELD_NONE) && (n < CNT_W'(MAX_RESULTS))) begin
        slot[n] = CHAR_PCT;
        n       = n + 1'b1;
      end
      if ((held_nxt[1]) && (n < CNT_W'(MAX_RESULTS))) begin
        slot[n] = digit_nxt;
        n       = n + 1'b1;
      end
      held_nxt  = HELD_NONE;
      digit_nxt = 8'd0;
    end
  end

  assign q_push          = accept && (n != '0);
  assign q_wdata.cnt     = n;
  assign q_wdata.bytes   = slot;
  assign q_wdata.str_end = in_ch.in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= HELD_NONE;
      digit_r <= 8'd0;
    end else if (accept) begin
      held_r  <= held_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

/* hw/rtl/upd_queue.sv */
// Short queue of result bundles between the classifier and the serialiser.
module upd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  upd_pkg::upd_entry_t wdata,
  input  logic                pop,
  output upd_pkg::upd_entry_t rdata,
  output logic                full,
  output logic                empty
);
  import upd_pkg::*;

  upd_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/upd_back.sv */
// Serialiser: head bundle to output register, one result per cycle unless stalled.
module upd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  upd_pkg::upd_entry_t q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  upd_out_if.source           out_ch
);
  import upd_pkg::*;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             run_last_r, run_last_nxt;
  logic             str_end_r, str_end_nxt;
  logic             load;
  logic             at_end;

  // The output register may be refilled when it is empty or being taken.
  assign load   = !valid_r || out_ch.ready;
  assign at_end = (idx_r == (q_rdata.cnt - 1'b1));
  assign q_pop  = load && !q_empty && at_end;

  always_comb begin
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    byte_nxt     = byte_r;
    run_last_nxt = run_last_r;
    str_end_nxt  = str_end_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        byte_nxt     = q_rdata.bytes[idx_r];
        run_last_nxt = at_end;
        str_end_nxt  = at_end && q_rdata.str_end;
        idx_nxt      = at_end ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    run_last_r <= run_last_nxt;
    str_end_r  <= str_end_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.string_end = str_end_r;

endmodule

/* test/url_decode_checker.sv */
// Checker for the URL percent decoder: predicts decoded bytes and compares results.
`timescale 1ns / 1ps

module url_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       string_end,
  output int         fail_count,
  output int         outstanding
);
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] dec_byte;
    logic       run_end;
    logic       str_end;
  } dec_char_t;

  dec_char_t  decoded_q[$];
  logic [7:0] step_bytes[$];
  logic [1:0] held_n;
  logic [7:0] held_ch;
  int         errs;

  function automatic logic char_is_hex(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
           (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_0 && c <= CHAR_9) v = c - CHAR_0;
    else if (c >= CHAR_LA && c <= CHAR_LF) v = c - CHAR_LA + 8'd10;
    else v = c - CHAR_UA + 8'd10;
    return v[3:0];
  endfunction

  // A character seen with nothing held.
  task take_plain(input logic [7:0] c);
    if (c == CHAR_PCT) held_n = HELD_PCT;
    else if (c == CHAR_PLUS) step_bytes.push_back(CHAR_SPACE);
    else step_bytes.push_back(c);
  endtask

  task decode_char(input logic [7:0] c, input logic last);
    logic [7:0] d;
    dec_char_t  r;
    step_bytes.delete();
    if (held_n == HELD_NONE) begin
      take_plain(c);
    end else if (held_n == HELD_PCT) begin
      if (char_is_hex(c)) begin
        held_ch = c;
        held_n  = HELD_DIGIT;
      end else begin
        held_n = HELD_NONE;
        step_bytes.push_back(CHAR_PCT);
        take_plain(c);
      end
    end else begin
      d       = held_ch;
      held_n  = HELD_NONE;
      held_ch = 8'd0;
      if (char_is_hex(c) && char_is_hex(d)) begin
        step_bytes.push_back({nibble_of(d), nibble_of(c)});
      end else begin
        step_bytes.push_back(CHAR_PCT);
        step_bytes.push_back(d);
        take_plain(c);
      end
    end
    // The end of a string flushes whatever is still held, literally.
    if (last) begin
      if (held_n >= HELD_PCT) step_bytes.push_back(CHAR_PCT);
      if (held_n >= HELD_DIGIT) step_bytes.push_back(held_ch);
      held_n  = HELD_NONE;
      held_ch = 8'd0;
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      r.dec_byte = step_bytes[i];
      r.run_end  = (i == step_bytes.size() - 1);
      r.str_end  = last && (i == step_bytes.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  initial begin
    held_n      = HELD_NONE;
    held_ch     = 8'd0;
    errs        = 0;
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    dec_char_t e;
    if (!rst_n) begin
      held_n  = HELD_NONE;
      held_ch = 8'd0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) decode_char(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h run_last %b string_end %b",
                 out_byte, run_last, string_end);
          errs++;
        end else begin
          e = decoded_q.pop_front();
          if (out_byte !== e.dec_byte) begin
            $error("out_byte: expected %h, got %h", e.dec_byte, out_byte);
            errs++;
          end
          if (run_last !== e.run_end) begin
            $error("run_last: expected %b, got %b", e.run_end, run_last);
            errs++;
          end
          if (string_end !== e.str_end) begin
            $error("string_end: expected %b, got %b", e.str_end, string_end);
            errs++;
          end
        end
      end
    end
    fail_count  <= errs;
    outstanding <= decoded_q.size();
  end

endmodule

/* test/url_percent_decoder_top_tb.sv */
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module url_percent_decoder_top_tb;
  import upd_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   no_idle;
  bit   long_hold_req;

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  url_decode_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.in_byte),
    .in_last     (in_ch.in_last),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .run_last    (out_ch.run_last),
    .string_end  (out_ch.string_end),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one request, after an occasional idle burst, and waits until it is taken.
  task send_char(input logic [7:0] c, input logic last);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hex_digit();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(CHAR_0 + k);
    if (k < 16) return 8'(CHAR_LA + (k - 10));
    return 8'(CHAR_UA + (k - 16));
  endfunction

  // Strings mix well-formed escapes and ordinary bytes with stray percent
  // signs, lone hex digits and plus signs.
  task send_random_strings(input int n_items);
    int         sent_n;
    int         len;
    int         r;
    logic [7:0] chars[$];
    sent_n = 0;
    while (sent_n < n_items) begin
      chars.delete();
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          chars.push_back(CHAR_PCT);
          chars.push_back(pick_hex_digit());
          chars.push_back(pick_hex_digit());
        end else if (r < 45) begin
          chars.push_back(CHAR_PCT);
        end else if (r < 55) begin
          chars.push_back(pick_hex_digit());
        end else if (r < 62) begin
          chars.push_back(CHAR_PLUS);
        end else begin
          chars.push_back(8'($urandom_range(1, 255)));
        end
      end
      for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
      sent_n += chars.size();
    end
  endtask

  // Result side: random stall bursts, one long hold on request, none at the end.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    no_idle        = 1'b0;
    long_hold_req  = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, a zero byte, valid escapes in both cases, broken escapes
    // and strings that end with characters still held.
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("+%4a%F0", 1'b0);
    send_text("%%4g", 1'b0);
    send_text("%z", 1'b0);
    send_text("x%", 1'b1);
    send_text("%b", 1'b1);
    send_text("+", 1'b1);
    send_text("%+", 1'b1);
    send_text("%4%", 1'b1);
    wait_drained();

    send_random_strings(170);
    wait_drained();

    // The receiver holds off while requests keep coming, so the block backs up.
    long_hold_req = 1'b1;
    send_random_strings(120);

    no_idle = 1'b1;
    send_random_strings(60);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
